/* rtl/acsi_pkg.sv */
// ----------------------------------------------------------------------------
// acsi_pkg
// shared types, opcodes and the identification string table of the acsi
// disk command responder
// ----------------------------------------------------------------------------
package acsi_pkg;

	localparam int NUM_TARGETS_DEF = 2;
	localparam int BEAT_BYTES_DEF  = 4;
	localparam int MAX_BEATS       = 64;

	// opcodes
	localparam logic [7:0] OP_TEST_READY = 8'h00;
	localparam logic [7:0] OP_REQ_SENSE  = 8'h03;
	localparam logic [7:0] OP_FORMAT     = 8'h04;
	localparam logic [7:0] OP_READ6      = 8'h08;
	localparam logic [7:0] OP_WRITE6     = 8'h0a;
	localparam logic [7:0] OP_INQUIRY    = 8'h12;
	localparam logic [7:0] OP_MODE_SENSE = 8'h1a;
	localparam logic [7:0] OP_CAPACITY   = 8'h25;
	localparam logic [7:0] OP_READ10     = 8'h28;
	localparam logic [7:0] OP_WRITE10    = 8'h2a;

	// sense codes
	localparam logic [7:0] SNS_NONE    = 8'h00;
	localparam logic [7:0] SNS_OPCODE  = 8'h20;
	localparam logic [7:0] SNS_RANGE   = 8'h21;
	localparam logic [7:0] SNS_LUN     = 8'h25;

	// register indexes
	localparam logic [1:0] REG_D0_PRESENT = 2'd0;
	localparam logic [1:0] REG_D0_BLOCKS  = 2'd1;
	localparam logic [1:0] REG_D1_PRESENT = 2'd2;
	localparam logic [1:0] REG_D1_BLOCKS  = 2'd3;

	// transfer direction
	localparam logic [1:0] DIR_NONE  = 2'd0;
	localparam logic [1:0] DIR_READ  = 2'd1;
	localparam logic [1:0] DIR_WRITE = 2'd2;

	typedef enum logic [2:0] {
		RSP_NONE,
		RSP_CAP,
		RSP_SENSE,
		RSP_INQ,
		RSP_MODE
	} rsp_kind_t;

	typedef struct packed {
		logic capture;
		logic decode;
		logic load;
		logic advance;
	} acsi_cmd_t;

	typedef struct packed {
		logic last;
	} acsi_sts_t;

	// inquiry bytes 8..43: vendor, product, revision, serial
	function automatic logic [7:0] id_byte(input logic [5:0] i);
		logic [7:0] b;
		case (i)
			6'd0:  b = 8'h54; 6'd1:  b = 8'h43; 6'd2:  b = 8'h36; 6'd3:  b = 8'h34;
			6'd4:  b = 8'h20; 6'd5:  b = 8'h20; 6'd6:  b = 8'h20; 6'd7:  b = 8'h20;
			6'd8:  b = 8'h44; 6'd9:  b = 8'h65; 6'd10: b = 8'h4d; 6'd11: b = 8'h69;
			6'd12: b = 8'h53; 6'd13: b = 8'h54; 6'd14: b = 8'h69; 6'd15: b = 8'h66;
			6'd16: b = 8'h79; 6'd17: b = 8'h20; 6'd18: b = 8'h48; 6'd19: b = 8'h44;
			6'd20: b = 8'h44; 6'd21: b = 8'h20; 6'd22: b = 8'h30; 6'd23: b = 8'h20;
			6'd24: b = 8'h38; 6'd25: b = 8'h33; 6'd26: b = 8'h32; 6'd27: b = 8'h20;
			6'd28: b = 8'h32; 6'd29: b = 8'h30; 6'd30: b = 8'h31; 6'd31: b = 8'h32;
			6'd32: b = 8'h30; 6'd33: b = 8'h39; 6'd34: b = 8'h32; 6'd35: b = 8'h39;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

/* rtl/acsi_ctrl.sv */
// ----------------------------------------------------------------------------
// acsi_ctrl
// command sequencer: take an item, decode it, then hand out its beats
// ----------------------------------------------------------------------------
module acsi_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  pending,
	input  logic                  out_ready,
	input  acsi_pkg::acsi_sts_t   sts,
	output logic                  in_ready,
	output logic                  out_valid,
	output acsi_pkg::acsi_cmd_t   cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_DECODE = 4'b0010,
		ST_LOAD   = 4'b0100,
		ST_SHOW   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_SHOW);

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (pending) state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
				state_d    = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_SHOW;
			end
			ST_SHOW: begin
				if (out_ready) begin
					cmd.advance = 1'b1;
					state_d     = sts.last ? ST_IDLE : ST_LOAD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule

/* rtl/acsi_dpath.sv */
// ----------------------------------------------------------------------------
// acsi_dpath
// command registers, decode, sense store and beat builder
// ----------------------------------------------------------------------------
module acsi_dpath #(
	parameter int NUM_TARGETS = acsi_pkg::NUM_TARGETS_DEF,
	parameter int BEAT_BYTES  = acsi_pkg::BEAT_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  acsi_pkg::acsi_cmd_t cmd,
	output acsi_pkg::acsi_sts_t sts,
	input  logic                cfg_wr_en,
	input  logic [1:0]          cfg_index,
	input  logic [22:0]         cfg_wdata,
	input  logic [7:0]          opcode,
	input  logic [7:0]          cdb_byte1,
	input  logic [7:0]          cdb_byte2,
	input  logic [7:0]          cdb_byte3,
	input  logic [7:0]          cdb_byte4,
	input  logic [7:0]          cdb_byte5,
	input  logic [7:0]          cdb_byte7,
	input  logic [7:0]          cdb_byte8,
	input  logic [2:0]          target_id,
	output logic [31:0]         data_word,
	output logic [2:0]          bytes_valid,
	output logic                last,
	output logic                is_nak,
	output logic                check_condition,
	output logic [1:0]          xfer_dir,
	output logic [31:0]         xfer_lba,
	output logic [16:0]         xfer_count
);

	localparam int BW   = (BEAT_BYTES > 4) ? 4 : BEAT_BYTES;
	localparam int MAXN = acsi_pkg::MAX_BEATS * BW;
	localparam int TW   = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;

	// configuration
	logic        d0_present_q, d1_present_q;
	logic [22:0] d0_blocks_q, d1_blocks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d0_present_q <= 1'b0;
			d1_present_q <= 1'b0;
			d0_blocks_q  <= '0;
			d1_blocks_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				acsi_pkg::REG_D0_PRESENT: d0_present_q <= cfg_wdata[0];
				acsi_pkg::REG_D0_BLOCKS:  d0_blocks_q  <= cfg_wdata;
				acsi_pkg::REG_D1_PRESENT: d1_present_q <= cfg_wdata[0];
				acsi_pkg::REG_D1_BLOCKS:  d1_blocks_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// captured command
	logic [7:0] op_q, b1_q, b2_q, b3_q, b4_q, b5_q, b7_q, b8_q;
	logic [2:0] t_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= opcode;
			b1_q <= cdb_byte1;
			b2_q <= cdb_byte2;
			b3_q <= cdb_byte3;
			b4_q <= cdb_byte4;
			b5_q <= cdb_byte5;
			b7_q <= cdb_byte7;
			b8_q <= cdb_byte8;
			t_q  <= target_id;
		end
	end

	// sense store
	logic [7:0] sense_q [NUM_TARGETS];

	// decode
	logic                blocks_c;
	logic [22:0]         blocks;
	logic                present, nak;
	logic [2:0]          lun;
	logic [8:0]          len6;
	logic [31:0]         lba;
	logic [16:0]         len;
	logic                in_range;
	logic [7:0]          sense_rd, sense_wr, rs_c;
	logic                chk_c;
	logic [1:0]          dir_c;
	logic [8:0]          n_c;
	acsi_pkg::rsp_kind_t kind_c;
	logic                is10;
	logic [TW-1:0]       tidx;

	assign blocks_c = 1'b0;
	assign tidx     = t_q[TW-1:0];

	always_comb begin
		present = 1'b0;
		blocks  = '0;
		if (t_q == 3'd0) begin
			present = d0_present_q;
			blocks  = d0_blocks_q;
		end else if (t_q == 3'd1) begin
			present = d1_present_q;
			blocks  = d1_blocks_q;
		end
		nak = (32'(t_q) >= 32'(NUM_TARGETS)) || !present || blocks_c;
	end

	assign lun      = b1_q[7:5];
	assign len6     = (b4_q == 8'd0) ? 9'd256 : {1'b0, b4_q};
	assign is10     = (op_q == acsi_pkg::OP_READ10) || (op_q == acsi_pkg::OP_WRITE10);
	assign lba      = is10 ? {b2_q, b3_q, b4_q, b5_q} : {11'd0, b1_q[4:0], b2_q, b3_q};
	assign len      = is10 ? {1'b0, b7_q, b8_q} : {8'd0, len6};
	assign in_range = ({1'b0, lba} + {16'd0, len}) <= {10'd0, blocks};
	assign sense_rd = nak ? 8'd0 : sense_q[tidx];

	always_comb begin
		chk_c    = 1'b0;
		dir_c    = acsi_pkg::DIR_NONE;
		n_c      = '0;
		kind_c   = acsi_pkg::RSP_NONE;
		rs_c     = '0;
		sense_wr = acsi_pkg::SNS_NONE;
		case (op_q)
			acsi_pkg::OP_CAPACITY: begin
				if (lun == 3'd0) begin
					kind_c = acsi_pkg::RSP_CAP;
					n_c    = 9'd8;
				end else begin
					chk_c    = 1'b1;
					sense_wr = acsi_pkg::SNS_LUN;
				end
			end
			acsi_pkg::OP_TEST_READY, acsi_pkg::OP_FORMAT: begin
				if (lun != 3'd0) begin
					chk_c    = 1'b1;
					sense_wr = acsi_pkg::SNS_LUN;
				end
			end
			acsi_pkg::OP_REQ_SENSE: begin
				kind_c = acsi_pkg::RSP_SENSE;
				n_c    = 9'd18;
				rs_c   = (lun != 3'd0) ? acsi_pkg::SNS_LUN : sense_rd;
			end
			acsi_pkg::OP_READ6, acsi_pkg::OP_WRITE6,
			acsi_pkg::OP_READ10, acsi_pkg::OP_WRITE10: begin
				if (lun != 3'd0) begin
					chk_c    = 1'b1;
					sense_wr = acsi_pkg::SNS_LUN;
				end else if (in_range) begin
					dir_c = ((op_q == acsi_pkg::OP_READ6) || (op_q == acsi_pkg::OP_READ10)) ?
						acsi_pkg::DIR_READ : acsi_pkg::DIR_WRITE;
				end else begin
					chk_c    = 1'b1;
					sense_wr = acsi_pkg::SNS_RANGE;
				end
			end
			acsi_pkg::OP_INQUIRY: begin
				kind_c = acsi_pkg::RSP_INQ;
				n_c    = {len6[8:1], 1'b0};
			end
			acsi_pkg::OP_MODE_SENSE: begin
				if (lun == 3'd0) begin
					kind_c = acsi_pkg::RSP_MODE;
					n_c    = {len6[8:1], 1'b0};
				end else begin
					chk_c    = 1'b1;
					sense_wr = acsi_pkg::SNS_LUN;
				end
			end
			default: begin
				chk_c    = 1'b1;
				sense_wr = acsi_pkg::SNS_OPCODE;
			end
		endcase
		if (32'(n_c) > 32'(MAXN)) n_c = 9'(MAXN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TARGETS; i++) sense_q[i] <= '0;
		end else if (cmd.decode && !nak) begin
			sense_q[tidx] <= sense_wr;
		end
	end

	// decoded response
	acsi_pkg::rsp_kind_t kind_q;
	logic        nak_q, chk_q;
	logic [1:0]  dir_q;
	logic [31:0] xlba_q;
	logic [16:0] xcnt_q;
	logic [8:0]  n_q, p_q;
	logic [7:0]  rs_q;
	logic [22:0] blocks_q;

	always_ff @(posedge clk) begin
		if (cmd.decode) begin
			kind_q   <= kind_c;
			nak_q    <= nak;
			chk_q    <= chk_c;
			dir_q    <= dir_c;
			xlba_q   <= (dir_c != acsi_pkg::DIR_NONE) ? lba : 32'd0;
			xcnt_q   <= (dir_c != acsi_pkg::DIR_NONE) ? len : 17'd0;
			n_q      <= n_c;
			rs_q     <= rs_c;
			blocks_q <= blocks;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decode) p_q <= '0;
		else if (cmd.advance) p_q <= 9'(p_q + 9'(BW));
	end

	// one response byte
	function automatic logic [7:0] rsp_byte(
		input acsi_pkg::rsp_kind_t kind,
		input logic [7:0]          idx,
		input logic [22:0]         blk,
		input logic [2:0]          t,
		input logic [2:0]          ln,
		input logic [7:0]          rs,
		input logic [7:0]          l8
	);
		logic [31:0] m;
		logic [7:0]  b;
		m = {9'd0, blk} - 32'd1;
		b = 8'h00;
		case (kind)
			acsi_pkg::RSP_CAP: begin
				case (idx)
					8'd0: b = m[31:24];
					8'd1: b = m[23:16];
					8'd2: b = m[15:8];
					8'd3: b = m[7:0];
					8'd6: b = 8'h02;
					default: b = 8'h00;
				endcase
			end
			acsi_pkg::RSP_SENSE: begin
				case (idx)
					8'd2:  b = (rs != 8'd0) ? 8'h05 : 8'h00;
					8'd7:  b = 8'h0b;
					8'd12: b = rs;
					default: b = 8'h00;
				endcase
			end
			acsi_pkg::RSP_INQ: begin
				if (idx == 8'd0) b = (ln != 3'd0) ? 8'h7f : 8'h00;
				else if (idx == 8'd2) b = 8'h02;
				else if (idx == 8'd4) b = 8'(l8 - 8'd5);
				else if (idx == 8'd30) b = 8'(8'h30 + {5'd0, t});
				else if (idx >= 8'd8 && idx < 8'd44) b = acsi_pkg::id_byte(6'(idx - 8'd8));
			end
			acsi_pkg::RSP_MODE: begin
				case (idx)
					8'd3:  b = 8'h08;
					8'd5:  b = {1'b0, blk[22:16]};
					8'd6:  b = blk[15:8];
					8'd7:  b = blk[7:0];
					8'd10: b = 8'h02;
					default: b = 8'h00;
				endcase
			end
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// beat builder
	logic [31:0] word_c;
	logic [2:0]  cnt_c;
	logic        last_c;
	logic [9:0]  idx_w;

	always_comb begin
		word_c = '0;
		cnt_c  = '0;
		idx_w  = '0;
		for (int j = 0; j < BW; j++) begin
			idx_w = {1'b0, p_q} + 10'(j);
			if (idx_w < {1'b0, n_q}) begin
				word_c[31 - 8 * j -: 8] = rsp_byte(kind_q, idx_w[7:0], blocks_q, t_q,
					b1_q[7:5], rs_q, b4_q);
				cnt_c = 3'(cnt_c + 3'd1);
			end
		end
		last_c = nak_q || (({1'b0, p_q} + 10'(BW)) >= {1'b0, n_q});
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			data_word       <= nak_q ? 32'd0 : word_c;
			bytes_valid     <= nak_q ? 3'd0 : cnt_c;
			last            <= last_c;
			is_nak          <= nak_q;
			check_condition <= last_c && !nak_q && chk_q;
			xfer_dir        <= (last_c && !nak_q) ? dir_q : acsi_pkg::DIR_NONE;
			xfer_lba        <= (last_c && !nak_q) ? xlba_q : 32'd0;
			xfer_count      <= (last_c && !nak_q) ? xcnt_q : 17'd0;
		end
	end

	assign sts.last = last;

endmodule

/* rtl/acsi_disk_command_responder.sv */
// ----------------------------------------------------------------------------
// acsi_disk_command_responder
// acsi hard-disk target: decodes one command block, keeps per-target sense
// and returns response beats ending in the completion status
// ----------------------------------------------------------------------------
// after a command item is taken the sequencer passes decode and load before
// the first beat shows; each beat is loaded, then held until taken, and the
// next command is taken only after the final beat of the last one is taken
// every beat comes from the one beat builder in the datapath
// an item with pending low is taken while idle and gives nothing
// reset: asynchronous, clears config registers, sense codes and sequencer
module acsi_disk_command_responder #(
	parameter int NUM_TARGETS = acsi_pkg::NUM_TARGETS_DEF,
	parameter int BEAT_BYTES  = acsi_pkg::BEAT_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [22:0] cfg_wdata,
	// command item
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  opcode,
	input  logic [7:0]  cdb_byte1,
	input  logic [7:0]  cdb_byte2,
	input  logic [7:0]  cdb_byte3,
	input  logic [7:0]  cdb_byte4,
	input  logic [7:0]  cdb_byte5,
	input  logic [7:0]  cdb_byte7,
	input  logic [7:0]  cdb_byte8,
	input  logic [2:0]  target_id,
	input  logic        pending,
	// response item
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] data_word,
	output logic [2:0]  bytes_valid,
	output logic        last,
	output logic        is_nak,
	output logic        check_condition,
	output logic [1:0]  xfer_dir,
	output logic [31:0] xfer_lba,
	output logic [16:0] xfer_count
);

	// sequencer to datapath commands and the last-beat status back
	acsi_pkg::acsi_cmd_t cmd;
	acsi_pkg::acsi_sts_t sts;

	// sequencer: idle, decode, load beat, hold beat
	acsi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.pending   (pending),
		.out_ready (out_ready),
		.sts       (sts),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// datapath: captured command, range check, sense store, beat register
	acsi_dpath #(
		.NUM_TARGETS (NUM_TARGETS),
		.BEAT_BYTES  (BEAT_BYTES)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.opcode          (opcode),
		.cdb_byte1       (cdb_byte1),
		.cdb_byte2       (cdb_byte2),
		.cdb_byte3       (cdb_byte3),
		.cdb_byte4       (cdb_byte4),
		.cdb_byte5       (cdb_byte5),
		.cdb_byte7       (cdb_byte7),
		.cdb_byte8       (cdb_byte8),
		.target_id       (target_id),
		.data_word       (data_word),
		.bytes_valid     (bytes_valid),
		.last            (last),
		.is_nak          (is_nak),
		.check_condition (check_condition),
		.xfer_dir        (xfer_dir),
		.xfer_lba        (xfer_lba),
		.xfer_count      (xfer_count)
	);

endmodule

/* rtl/acsi_chk.sv */
// ----------------------------------------------------------------------------
// acsi_chk
// port-level checks of the responder, bound to the top level
// ----------------------------------------------------------------------------
module acsi_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] data_word,
	input logic [2:0]  bytes_valid,
	input logic        last,
	input logic        is_nak,
	input logic        check_condition,
	input logic [1:0]  xfer_dir
);

	// a held beat stays unchanged
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_word) && $stable(last))
		else $error("beat changed while stalled");

	// one command at a time: no new item while a beat is shown
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a beat is shown");

	// a nak is a single empty completion
	a_nak: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_nak |-> last && (bytes_valid == 3'd0) && !check_condition)
		else $error("malformed nak");

	// status and transfer request only on the final beat
	a_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !check_condition && (xfer_dir == 2'd0) && !is_nak)
		else $error("completion fields on a middle beat");

	// after the final beat is taken the block is ready again
	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> in_ready)
		else $error("not ready after completion");

endmodule

bind acsi_disk_command_responder acsi_chk u_acsi_chk (.*);

/* verif/tb_acsi_disk_command_responder.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_acsi_disk_command_responder
// self-checking bench for the acsi disk command responder: an in-bench model
// of the decode, range check, sense bookkeeping and beat packing predicts
// every response item, and a checker compares each one in order while both
// handshakes are throttled in several idle and stall phases
// ----------------------------------------------------------------------------
module tb_acsi_disk_command_responder;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 150;

	// inquiry identification bytes 8..43
	localparam logic [7:0] ID_TEXT [0:35] = '{
		8'h54, 8'h43, 8'h36, 8'h34, 8'h20, 8'h20, 8'h20, 8'h20,
		8'h44, 8'h65, 8'h4d, 8'h69, 8'h53, 8'h54, 8'h69, 8'h66,
		8'h79, 8'h20, 8'h48, 8'h44, 8'h44, 8'h20, 8'h30, 8'h20,
		8'h38, 8'h33, 8'h32, 8'h20, 8'h32, 8'h30, 8'h31, 8'h32,
		8'h30, 8'h39, 8'h32, 8'h39};

	typedef struct {
		logic [7:0] op, b1, b2, b3, b4, b5, b7, b8;
		logic [2:0] tgt;
		logic       pend;
	} cmd_t;

	typedef struct packed {
		logic [31:0] data;
		logic [2:0]  nbytes;
		logic        last;
		logic        nak;
		logic        chk;
		logic [1:0]  dir;
		logic [31:0] lba;
		logic [16:0] count;
	} beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [22:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  opcode = '0, cdb_byte1 = '0, cdb_byte2 = '0, cdb_byte3 = '0;
	logic [7:0]  cdb_byte4 = '0, cdb_byte5 = '0, cdb_byte7 = '0, cdb_byte8 = '0;
	logic [2:0]  target_id = '0;
	logic        pending = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] data_word;
	logic [2:0]  bytes_valid;
	logic        last, is_nak, check_condition;
	logic [1:0]  xfer_dir;
	logic [31:0] xfer_lba;
	logic [16:0] xfer_count;

	// model copy of configuration and per-target sense
	logic        disk_present [0:1];
	logic [22:0] disk_blocks [0:1];
	logic [7:0]  target_sense [0:1];

	beat_t expected_beats [$];
	int    mismatches = 0;
	int    send_idle_pct = 0;
	int    recv_stall_pct = 0;
	int    hold_left = 0;
	int    quiet_cycles = 0;

	acsi_disk_command_responder uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .cdb_byte1(cdb_byte1), .cdb_byte2(cdb_byte2),
		.cdb_byte3(cdb_byte3), .cdb_byte4(cdb_byte4), .cdb_byte5(cdb_byte5),
		.cdb_byte7(cdb_byte7), .cdb_byte8(cdb_byte8),
		.target_id(target_id), .pending(pending),
		.out_valid(out_valid), .out_ready(out_ready),
		.data_word(data_word), .bytes_valid(bytes_valid), .last(last),
		.is_nak(is_nak), .check_condition(check_condition),
		.xfer_dir(xfer_dir), .xfer_lba(xfer_lba), .xfer_count(xfer_count)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// works out the response items of one accepted command and queues them
	function automatic void predict_response(input cmd_t c);
		logic [7:0]  rsp [0:255];
		int          n, nres, t;
		logic [2:0]  lun;
		logic        chk, pres;
		logic [1:0]  dir;
		logic [31:0] lba, xlba, cap;
		logic [16:0] len, xcnt;
		logic [22:0] blk;
		logic [32:0] span;
		beat_t       r;
		n = 0; chk = 0; dir = acsi_pkg::DIR_NONE; xlba = '0; xcnt = '0;
		if (!c.pend)
			return;
		t = c.tgt;
		pres = 1'b0;
		blk = '0;
		if (t < 2) begin
			pres = disk_present[t];
			blk = disk_blocks[t];
		end
		if (!pres) begin
			// absent or unsupported target: bare not-acknowledge
			r = '0;
			r.last = 1'b1;
			r.nak = 1'b1;
			expected_beats.push_back(r);
			return;
		end
		for (int i = 0; i < 256; i++)
			rsp[i] = 8'h00;
		lun = c.b1[7:5];
		lba = {11'd0, c.b1[4:0], c.b2, c.b3};
		len = (c.b4 == 8'd0) ? 17'd256 : {9'd0, c.b4};
		case (c.op)
			acsi_pkg::OP_CAPACITY: begin
				if (lun == 0) begin
					// an empty disk wraps to all ones
					cap = {9'd0, blk} - 32'd1;
					{rsp[0], rsp[1], rsp[2], rsp[3]} = cap;
					rsp[6] = 8'd2;
					n = 8;
					target_sense[t] = acsi_pkg::SNS_NONE;
				end else begin
					chk = 1; target_sense[t] = acsi_pkg::SNS_LUN;
				end
			end
			acsi_pkg::OP_TEST_READY, acsi_pkg::OP_FORMAT: begin
				if (lun == 0) target_sense[t] = acsi_pkg::SNS_NONE;
				else begin
					chk = 1; target_sense[t] = acsi_pkg::SNS_LUN;
				end
			end
			acsi_pkg::OP_REQ_SENSE: begin
				if (lun != 0) target_sense[t] = acsi_pkg::SNS_LUN;
				rsp[7] = 8'h0b;
				if (target_sense[t] != acsi_pkg::SNS_NONE) begin
					rsp[2] = 8'h05;
					rsp[12] = target_sense[t];
				end
				n = 18;
				target_sense[t] = acsi_pkg::SNS_NONE;
			end
			acsi_pkg::OP_READ6, acsi_pkg::OP_WRITE6,
			acsi_pkg::OP_READ10, acsi_pkg::OP_WRITE10: begin
				if (lun == 0) begin
					if (c.op == acsi_pkg::OP_READ10 || c.op == acsi_pkg::OP_WRITE10) begin
						lba = {c.b2, c.b3, c.b4, c.b5};
						len = {1'b0, c.b7, c.b8};
					end
					// 33-bit sum so a huge address cannot wrap past the check
					span = {1'b0, lba} + {16'd0, len};
					if (span <= {10'd0, blk}) begin
						dir = (c.op == acsi_pkg::OP_READ6 || c.op == acsi_pkg::OP_READ10) ?
							acsi_pkg::DIR_READ : acsi_pkg::DIR_WRITE;
						xlba = lba;
						xcnt = len;
						target_sense[t] = acsi_pkg::SNS_NONE;
					end else begin
						chk = 1; target_sense[t] = acsi_pkg::SNS_RANGE;
					end
				end else begin
					chk = 1; target_sense[t] = acsi_pkg::SNS_LUN;
				end
			end
			acsi_pkg::OP_INQUIRY: begin
				rsp[2] = 8'd2;
				rsp[4] = len[7:0] - 8'd5;
				for (int i = 0; i < 36; i++)
					rsp[8 + i] = ID_TEXT[i];
				rsp[30] = 8'h30 + t[7:0];
				if (lun != 0) rsp[0] = 8'h7f;
				n = len & 17'h1fe;
				target_sense[t] = acsi_pkg::SNS_NONE;
			end
			acsi_pkg::OP_MODE_SENSE: begin
				if (lun == 0) begin
					rsp[3] = 8'd8;
					rsp[5] = {1'b0, blk[22:16]};
					rsp[6] = blk[15:8];
					rsp[7] = blk[7:0];
					rsp[10] = 8'd2;
					n = len & 17'h1fe;
					target_sense[t] = acsi_pkg::SNS_NONE;
				end else begin
					chk = 1; target_sense[t] = acsi_pkg::SNS_LUN;
				end
			end
			default: begin
				chk = 1; target_sense[t] = acsi_pkg::SNS_OPCODE;
			end
		endcase
		nres = (n + 3) / 4;
		if (nres > acsi_pkg::MAX_BEATS) begin
			nres = acsi_pkg::MAX_BEATS; n = acsi_pkg::MAX_BEATS * 4;
		end
		if (nres == 0) nres = 1;
		for (int k = 0; k < nres; k++) begin
			r = '0;
			for (int j = 0; j < 4; j++)
				if (k * 4 + j < n) begin
					r.data[31 - 8 * j -: 8] = rsp[k * 4 + j];
					r.nbytes++;
				end
			if (k == nres - 1) begin
				r.last = 1'b1;
				r.chk = chk;
				r.dir = dir;
				r.lba = xlba;
				r.count = xcnt;
			end
			expected_beats.push_back(r);
		end
	endfunction

	// offers one command after an optional random gap and waits for it to be taken
	task automatic send_cmd(input cmd_t c);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= c.op;
		cdb_byte1 <= c.b1; cdb_byte2 <= c.b2; cdb_byte3 <= c.b3;
		cdb_byte4 <= c.b4; cdb_byte5 <= c.b5; cdb_byte7 <= c.b7; cdb_byte8 <= c.b8;
		target_id <= c.tgt;
		pending <= c.pend;
		do @(posedge clk); while (!in_ready);
		predict_response(c);
	endtask

	function automatic cmd_t make_cmd(input logic [7:0] op, input logic [7:0] b1,
			input logic [31:0] addr, input logic [15:0] len10, input logic [7:0] b4,
			input logic [2:0] tgt);
		cmd_t c;
		c.op = op; c.b1 = b1;
		c.tgt = tgt; c.pend = 1'b1;
		c.b7 = len10[15:8]; c.b8 = len10[7:0];
		if (op == acsi_pkg::OP_READ10 || op == acsi_pkg::OP_WRITE10) begin
			{c.b2, c.b3, c.b4, c.b5} = addr;
		end else begin
			c.b2 = addr[15:8]; c.b3 = addr[7:0]; c.b4 = b4; c.b5 = addr[31:24];
		end
		return c;
	endfunction

	// lets the block go idle, then writes all four registers
	task automatic set_disks(input logic p0, input logic [22:0] n0,
			input logic p1, input logic [22:0] n1);
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (140) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= acsi_pkg::REG_D0_PRESENT; cfg_wdata <= {22'd0, p0};
		@(posedge clk);
		cfg_index <= acsi_pkg::REG_D0_BLOCKS; cfg_wdata <= n0;
		@(posedge clk);
		cfg_index <= acsi_pkg::REG_D1_PRESENT; cfg_wdata <= {22'd0, p1};
		@(posedge clk);
		cfg_index <= acsi_pkg::REG_D1_BLOCKS; cfg_wdata <= n1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		disk_present[0] = p0; disk_blocks[0] = n0;
		disk_present[1] = p1; disk_blocks[1] = n1;
	endtask

	// random command, mostly well formed with an in-range address
	function automatic cmd_t random_cmd();
		cmd_t        c;
		logic [7:0]  ops [0:9];
		logic [31:0] addr, room;
		int          t;
		ops = '{acsi_pkg::OP_TEST_READY, acsi_pkg::OP_REQ_SENSE, acsi_pkg::OP_FORMAT,
			acsi_pkg::OP_READ6, acsi_pkg::OP_WRITE6, acsi_pkg::OP_INQUIRY,
			acsi_pkg::OP_MODE_SENSE, acsi_pkg::OP_CAPACITY, acsi_pkg::OP_READ10,
			acsi_pkg::OP_WRITE10};
		c.op = ($urandom_range(99) < 90) ? ops[$urandom_range(9)] : 8'($urandom);
		c.b1 = 8'($urandom); c.b2 = 8'($urandom); c.b3 = 8'($urandom);
		c.b4 = 8'($urandom); c.b5 = 8'($urandom);
		c.b7 = 8'($urandom); c.b8 = 8'($urandom);
		if ($urandom_range(99) < 80) c.b1[7:5] = 3'd0;
		c.tgt = ($urandom_range(99) < 85) ? 3'($urandom_range(1)) : 3'($urandom);
		c.pend = ($urandom_range(99) < 95);
		t = c.tgt;
		if (t < 2 && $urandom_range(99) < 60 && disk_blocks[t] != 0) begin
			// aim inside the disk with a short length
			addr = $urandom_range(disk_blocks[t] - 1);
			room = disk_blocks[t] - addr;
			if (c.op == acsi_pkg::OP_READ10 || c.op == acsi_pkg::OP_WRITE10) begin
				{c.b2, c.b3, c.b4, c.b5} = addr;
				{c.b7, c.b8} = 16'($urandom_range(room > 300 ? 300 : room));
			end else if (addr < 32'h200000) begin
				{c.b1[4:0], c.b2, c.b3} = addr[20:0];
				c.b4 = 8'($urandom_range(room > 255 ? 255 : room));
			end
		end
		return c;
	endfunction

	task automatic test_nak_when_absent();
		cmd_t c;
		c = make_cmd(acsi_pkg::OP_CAPACITY, 8'h00, '0, '0, '0, 3'd0);
		send_cmd(c);
		c.tgt = 3'd1;
		send_cmd(c);
		c.tgt = 3'd7;
		send_cmd(c);
		c.pend = 1'b0;
		send_cmd(c);
	endtask

	task automatic test_directed();
		set_disks(1'b1, 23'd1000, 1'b1, 23'd0);
		send_cmd(make_cmd(acsi_pkg::OP_CAPACITY, 8'h00, '0, '0, '0, 3'd0));
		send_cmd(make_cmd(acsi_pkg::OP_CAPACITY, 8'h00, '0, '0, '0, 3'd1));
		send_cmd(make_cmd(acsi_pkg::OP_TEST_READY, 8'h00, '0, '0, '0, 3'd0));
		send_cmd(make_cmd(acsi_pkg::OP_FORMAT, 8'h00, '0, '0, '0, 3'd0));
		send_cmd(make_cmd(acsi_pkg::OP_REQ_SENSE, 8'h00, '0, '0, 8'd18, 3'd0));
		send_cmd(make_cmd(8'hff, 8'hff, 32'hffffffff, 16'hffff, 8'hff, 3'd0));
		send_cmd(make_cmd(acsi_pkg::OP_REQ_SENSE, 8'h00, '0, '0, 8'd18, 3'd0));
		// nonzero logical unit cases
		send_cmd(make_cmd(acsi_pkg::OP_CAPACITY, 8'he0, '0, '0, '0, 3'd0));
		send_cmd(make_cmd(acsi_pkg::OP_REQ_SENSE, 8'h60, '0, '0, '0, 3'd0));
		send_cmd(make_cmd(acsi_pkg::OP_INQUIRY, 8'h20, '0, '0, 8'd44, 3'd1));
		send_cmd(make_cmd(acsi_pkg::OP_MODE_SENSE, 8'h40, '0, '0, 8'd12, 3'd0));
		// allocation lengths: zero means 256, odd ones rounded down
		send_cmd(make_cmd(acsi_pkg::OP_INQUIRY, 8'h00, '0, '0, 8'd0, 3'd0));
		send_cmd(make_cmd(acsi_pkg::OP_INQUIRY, 8'h00, '0, '0, 8'd5, 3'd0));
		send_cmd(make_cmd(acsi_pkg::OP_MODE_SENSE, 8'h00, '0, '0, 8'd0, 3'd0));
		send_cmd(make_cmd(acsi_pkg::OP_MODE_SENSE, 8'h00, '0, '0, 8'd13, 3'd1));
		// range edges
		send_cmd(make_cmd(acsi_pkg::OP_READ6, 8'h00, 32'd999, '0, 8'd1, 3'd0));
		send_cmd(make_cmd(acsi_pkg::OP_READ6, 8'h00, 32'd0, '0, 8'd0, 3'd0));
		send_cmd(make_cmd(acsi_pkg::OP_REQ_SENSE, 8'h00, '0, '0, '0, 3'd0));
		send_cmd(make_cmd(acsi_pkg::OP_WRITE6, 8'h1f, 32'h0000ffff, '0, 8'd1, 3'd0));
		send_cmd(make_cmd(acsi_pkg::OP_WRITE6, 8'h00, 32'd744, '0, 8'd0, 3'd0));
		send_cmd(make_cmd(acsi_pkg::OP_READ10, 8'h00, 32'd1000, 16'd0, '0, 3'd0));
		send_cmd(make_cmd(acsi_pkg::OP_WRITE10, 8'h00, 32'hffffffff, 16'hffff, '0, 3'd0));
		send_cmd(make_cmd(acsi_pkg::OP_READ10, 8'h00, 32'd0, 16'd0, '0, 3'd1));
		send_cmd(make_cmd(acsi_pkg::OP_WRITE10, 8'h00, 32'd0, 16'd1, '0, 3'd1));
	endtask

	task automatic test_random_phase(input int items, input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (items) send_cmd(random_cmd());
	endtask

	// receiver stops for a long stretch while commands keep coming
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 400;
		repeat (20) send_cmd(random_cmd());
	endtask

	// response checker and receiver throttle
	always @(posedge clk) begin
		beat_t got, want;
		if (out_valid && out_ready) begin
			got = '{data_word, bytes_valid, last, is_nak, check_condition,
				xfer_dir, xfer_lba, xfer_count};
			if (expected_beats.size() == 0)
				report_mismatch($sformatf("unexpected item %h", got));
			else begin
				want = expected_beats.pop_front();
				if (got !== want)
					report_mismatch($sformatf("got %h want %h", got, want));
			end
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog on cycles with no item moving either way
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < 2; i++) begin
			disk_present[i] = 1'b0; disk_blocks[i] = '0;
			target_sense[i] = acsi_pkg::SNS_NONE;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		recv_stall_pct = 0;
		test_nak_when_absent();
		test_directed();
		set_disks(1'b1, 23'($urandom_range(2000, 1)), 1'b1, 23'($urandom));
		test_random_phase(100, 0, 0);
		set_disks(1'b1, 23'h7fffff, 1'b0, 23'($urandom));
		test_random_phase(100, 51, 0);
		set_disks(1'b1, 23'($urandom_range(16, 1)), 1'b1, 23'($urandom_range(16, 1)));
		test_random_phase(100, 0, 51);
		test_backpressure();
		set_disks(1'b0, 23'($urandom), 1'b1, 23'h7fffff);
		test_random_phase(50, 11, 11);
		set_disks(1'b1, 23'd0, 1'b1, 23'($urandom_range(500)));
		test_random_phase(50, 11, 11);
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
